>>> hw/rtl/prfe_pkg.sv
// ----------------------------------------------------------------------------
// prfe_pkg
// Shared types, sizes and codes for the fixed-ends permutation rank block.
// ----------------------------------------------------------------------------
package prfe_pkg;

  localparam int N_POS    = 16;
  localparam int POS_BITS = 4;
  localparam int IDX_W    = (N_POS > 1) ? $clog2(N_POS) : 1;
  localparam int ROW_W    = 64;
  localparam int CNT_W    = 5;
  localparam int END_W    = CNT_W + 1;
  localparam int RANK_W   = 45;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int GRP      = 4;
  localparam int NGRP     = (N_POS + GRP - 1) / GRP;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FRONT_BAD = 3'd2;
  localparam logic [STAT_W-1:0] ST_BACK_BAD  = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_CFG   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WORKING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd2;

  typedef logic [N_POS-1:0][POS_BITS-1:0] row_vals_t;
  typedef logic [N_POS-1:0][RANK_W-1:0]   prod_vec_t;

  typedef struct packed {
    logic front_bad;
    logic back_bad;
  } lane_flags_t;

  typedef lane_flags_t [N_POS-1:0] flag_vec_t;

  typedef struct packed {
    logic [CNT_W-1:0] working;
    logic [CNT_W-1:0] front;
    logic [CNT_W-1:0] total;
  } cfg_t;

  localparam logic [RANK_W-1:0] FACT [16] = '{
    45'd1, 45'd1, 45'd2, 45'd6, 45'd24, 45'd120, 45'd720, 45'd5040,
    45'd40320, 45'd362880, 45'd3628800, 45'd39916800, 45'd479001600,
    45'd6227020800, 45'd87178291200, 45'd1307674368000
  };

endpackage

>>> hw/rtl/prfe_lane.sv
// ----------------------------------------------------------------------------
// prfe_lane
// One position lane: counts later smaller working values, checks the fixed
// ends, and weights the count by the factorial of the remaining length.
// ----------------------------------------------------------------------------
module prfe_lane (
  input  logic                        clk,
  input  logic [prfe_pkg::IDX_W-1:0]  lane_idx,
  input  prfe_pkg::row_vals_t         vals,
  input  prfe_pkg::cfg_t              cfg,
  output logic [prfe_pkg::RANK_W-1:0] prod,
  output prfe_pkg::lane_flags_t       flags
);
  import prfe_pkg::*;

  logic [END_W-1:0]    idx_ext;
  logic [END_W-1:0]    end_pos;
  logic [POS_BITS-1:0] own_val;
  logic                own_ok;
  logic                in_work;
  logic [CNT_W-1:0]    cnt;
  logic [END_W-1:0]    weight_full;
  lane_flags_t         flags_c;

  logic [CNT_W-1:0]    cnt_r;
  logic                work_r;
  logic [IDX_W-1:0]    weight_r;
  lane_flags_t         flags1_r;
  logic [RANK_W-1:0]   prod_r;
  lane_flags_t         flags2_r;

  assign idx_ext     = END_W'(lane_idx);
  assign end_pos     = END_W'(cfg.front) + END_W'(cfg.working);
  assign own_val     = vals[lane_idx];
  assign own_ok      = (END_W'(own_val) == idx_ext);
  assign in_work     = (idx_ext >= END_W'(cfg.front)) && (idx_ext < end_pos);
  assign weight_full = end_pos - idx_ext - END_W'(1);

  always_comb begin
    cnt = '0;
    for (int j = 0; j < N_POS; j++) begin
      if ((END_W'(j) > idx_ext) && (END_W'(j) < end_pos) && (vals[j] < own_val)) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  always_comb begin
    flags_c.front_bad = (idx_ext < END_W'(cfg.front)) && !own_ok;
    flags_c.back_bad  = (idx_ext >= end_pos) && (idx_ext < END_W'(cfg.total)) && !own_ok;
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt;
    work_r   <= in_work;
    weight_r <= weight_full[IDX_W-1:0];
    flags1_r <= flags_c;
    prod_r   <= work_r ? RANK_W'(RANK_W'(cnt_r) * FACT[weight_r]) : '0;
    flags2_r <= flags1_r;
  end

  assign prod  = prod_r;
  assign flags = flags2_r;

endmodule

>>> hw/rtl/prfe_merge.sv
// ----------------------------------------------------------------------------
// prfe_merge
// Sums the lane products in a registered tree and resolves the status code.
// ----------------------------------------------------------------------------
module prfe_merge (
  input  logic                        clk,
  input  prfe_pkg::prod_vec_t         prods,
  input  prfe_pkg::flag_vec_t         flags,
  input  logic                        too_long,
  input  prfe_pkg::cfg_t              cfg,
  output logic [prfe_pkg::RANK_W-1:0] rank,
  output logic [prfe_pkg::STAT_W-1:0] status
);
  import prfe_pkg::*;

  logic [RANK_W-1:0] part [NGRP];
  logic [STAT_W-1:0] stat_c;
  logic              front_any;
  logic              back_any;
  logic              bad_cfg;
  logic [RANK_W-1:0] total_sum;

  logic [RANK_W-1:0] part_r [NGRP];
  logic [STAT_W-1:0] stat_r;
  logic [RANK_W-1:0] rank_r;
  logic [STAT_W-1:0] status_r;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < N_POS) begin
          part[g] = part[g] + prods[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    front_any = 1'b0;
    back_any  = 1'b0;
    for (int i = 0; i < N_POS; i++) begin
      front_any = front_any | flags[i].front_bad;
      back_any  = back_any | flags[i].back_bad;
    end
    bad_cfg = (cfg.total > CNT_W'(N_POS)) ||
              ((END_W'(cfg.front) + END_W'(cfg.working)) > END_W'(cfg.total));
    if (bad_cfg) begin
      stat_c = ST_BAD_CFG;
    end else if (too_long) begin
      stat_c = ST_TOO_LONG;
    end else if (front_any) begin
      stat_c = ST_FRONT_BAD;
    end else if (back_any) begin
      stat_c = ST_BACK_BAD;
    end else begin
      stat_c = ST_OK;
    end
  end

  always_comb begin
    total_sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      total_sum = total_sum + part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    part_r   <= part;
    stat_r   <= stat_c;
    rank_r   <= (stat_r == ST_OK) ? total_sum : '0;
    status_r <= stat_r;
  end

  assign rank   = rank_r;
  assign status = status_r;

endmodule

>>> hw/rtl/permutation_rank_fixed_ends_top.sv
// ----------------------------------------------------------------------------
// permutation_rank_fixed_ends_top
// Lexicographic rank of the working section of a permutation row whose
// leading and trailing positions must hold their own index.
//
// A row is taken at a clock edge where start is high and busy is low; busy
// stays low, so a new row may be given in every cycle. Each row produces one
// result transfer: out_rank and out_status are valid for exactly the one
// cycle in which out_valid is high. A row passes the input register, two lane
// stages and two adder tree stages. The block sustains one row per cycle, set
// by the sixteen counting lanes working in parallel and the registered adder
// tree that merges their products. The receiver cannot stall the result
// channel, and none is needed. Configuration registers are written through
// cfg_we, cfg_index and cfg_data while no row is in flight; the user must
// keep to this, as the block does not enforce it. Indexes beyond the three
// registers are ignored. A synchronous reset drops rows in flight and loads
// the registers with working count 8, front count 0 and total count 8.
// ----------------------------------------------------------------------------
module permutation_rank_fixed_ends_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [prfe_pkg::ROW_W-1:0]     in_row_packed,
  input  logic [prfe_pkg::CNT_W-1:0]     in_row_length,
  output logic                           out_valid,
  output logic [prfe_pkg::RANK_W-1:0]    out_rank,
  output logic [prfe_pkg::STAT_W-1:0]    out_status,
  input  logic                           cfg_we,
  input  logic [prfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prfe_pkg::CNT_W-1:0]     cfg_data
);
  import prfe_pkg::*;

  localparam int VLD_STAGES = 5;

  cfg_t                  cfg_r;
  cfg_t                  cfg_nxt;
  logic [VLD_STAGES-1:0] vld_r;
  logic [VLD_STAGES-1:0] vld_nxt;
  logic [ROW_W-1:0]      row_r;
  logic [CNT_W-1:0]      len_r;
  logic                  tl1_r;
  logic                  tl2_r;
  row_vals_t             vals;
  prod_vec_t             prods;
  flag_vec_t             flags;

  assign busy = 1'b0;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WORKING: cfg_nxt.working = cfg_data;
        REG_FRONT:   cfg_nxt.front   = cfg_data;
        REG_TOTAL:   cfg_nxt.total   = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
    vld_nxt = {vld_r[VLD_STAGES-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.working <= CNT_W'(8);
      cfg_r.front   <= CNT_W'(0);
      cfg_r.total   <= CNT_W'(8);
      vld_r         <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      row_r <= in_row_packed;
      len_r <= in_row_length;
    end
    tl1_r <= (len_r > cfg_r.total);
    tl2_r <= tl1_r;
  end

  always_comb begin
    for (int k = 0; k < N_POS; k++) begin
      if (CNT_W'(k) < len_r) begin
        vals[k] = row_r[k * POS_BITS +: POS_BITS];
      end else begin
        vals[k] = POS_BITS'(k);
      end
    end
  end

  for (genvar g = 0; g < N_POS; g++) begin : g_lane
    prfe_lane u_lane (
      .clk      (clk),
      .lane_idx (IDX_W'(g)),
      .vals     (vals),
      .cfg      (cfg_r),
      .prod     (prods[g]),
      .flags    (flags[g])
    );
  end

  prfe_merge u_merge (
    .clk      (clk),
    .prods    (prods),
    .flags    (flags),
    .too_long (tl2_r),
    .cfg      (cfg_r),
    .rank     (out_rank),
    .status   (out_status)
  );

  assign out_valid = vld_r[VLD_STAGES-1];

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the fixed-ends permutation rank block. Directed rows cover
// the extreme values, every status code and the layout corner cases. Random
// phases follow, each with its own register setting. Each accepted row
// without a given result is ranked by a local predictor, and each result
// transfer is checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
  import prfe_pkg::*;

  localparam int LATENCY = 5;
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 100000;
  localparam int N_DIR = 25;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] status;
  } rank_result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  working;
    logic [CNT_W-1:0]  front;
    logic [CNT_W-1:0]  total;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  len;
    logic              known;
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] status;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{5'd8, 5'd0, 5'd8, 64'h0000000076543210, 5'd8, 1'b1, 45'd0, ST_OK},
    '{5'd8, 5'd0, 5'd8, 64'h0000000001234567, 5'd8, 1'b1, 45'd40319, ST_OK},
    '{5'd8, 5'd0, 5'd8, 64'h0000000076543201, 5'd8, 1'b1, 45'd5040, ST_OK},
    '{5'd8, 5'd0, 5'd8, 64'h0000000000000000, 5'd0, 1'b1, 45'd0, ST_OK},
    '{5'd8, 5'd0, 5'd8, 64'hFFFFFFFFFFFFFFFF, 5'd8, 1'b0, 45'd0, ST_OK},
    '{5'd8, 5'd0, 5'd8, 64'h0000000012345670, 5'd9, 1'b1, 45'd0, ST_TOO_LONG},
    '{5'd8, 5'd0, 5'd8, 64'hFFFFFFFFFFFFFFFF, 5'd31, 1'b1, 45'd0, ST_TOO_LONG},
    '{5'd8, 5'd0, 5'd8, 64'hA5A5A5A535127460, 5'd5, 1'b0, 45'd0, ST_OK},
    '{5'd16, 5'd0, 5'd16, 64'hFEDCBA9876543210, 5'd16, 1'b1, 45'd0, ST_OK},
    '{5'd16, 5'd0, 5'd16, 64'h0123456789ABCDEF, 5'd16, 1'b1, 45'd20922789887999,
      ST_OK},
    '{5'd16, 5'd0, 5'd16, 64'h0000000000000000, 5'd16, 1'b0, 45'd0, ST_OK},
    '{5'd16, 5'd0, 5'd16, 64'h5A3C0F96E1B7D248, 5'd16, 1'b0, 45'd0, ST_OK},
    '{5'd4, 5'd2, 5'd8, 64'h0000000076543211, 5'd8, 1'b1, 45'd0, ST_FRONT_BAD},
    '{5'd4, 5'd2, 5'd8, 64'h0000000066543210, 5'd8, 1'b1, 45'd0, ST_BACK_BAD},
    '{5'd4, 5'd2, 5'd8, 64'h0000000066543211, 5'd8, 1'b1, 45'd0, ST_FRONT_BAD},
    '{5'd4, 5'd2, 5'd8, 64'h0000000076235410, 5'd8, 1'b0, 45'd0, ST_OK},
    '{5'd4, 5'd2, 5'd8, 64'hFFFFFFFFFFFFF210, 5'd3, 1'b0, 45'd0, ST_OK},
    '{5'd0, 5'd16, 5'd16, 64'hFEDCBA9876543210, 5'd16, 1'b1, 45'd0, ST_OK},
    '{5'd0, 5'd16, 5'd16, 64'h0000000000000000, 5'd1, 1'b1, 45'd0, ST_OK},
    '{5'd0, 5'd16, 5'd16, 64'h0000000000000000, 5'd2, 1'b1, 45'd0, ST_FRONT_BAD},
    '{5'd8, 5'd4, 5'd8, 64'h0000000076543210, 5'd8, 1'b1, 45'd0, ST_BAD_CFG},
    '{5'd16, 5'd0, 5'd17, 64'h0000000000000000, 5'd0, 1'b1, 45'd0, ST_BAD_CFG},
    '{5'd31, 5'd31, 5'd31, 64'hFEDCBA9876543210, 5'd16, 1'b1, 45'd0, ST_BAD_CFG},
    '{5'd0, 5'd0, 5'd0, 64'h0000000000000000, 5'd0, 1'b1, 45'd0, ST_OK},
    '{5'd0, 5'd0, 5'd0, 64'h0000000000000000, 5'd1, 1'b1, 45'd0, ST_TOO_LONG}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ROW_W-1:0]     in_row_packed;
  logic [CNT_W-1:0]     in_row_length;
  logic                 out_valid;
  logic [RANK_W-1:0]    out_rank;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  cfg_t         cfg_shadow;
  rank_result_t pending_ranks [$];
  rank_result_t oldest_rank;
  int           errors;
  int           cycles;
  int           rows_sent;

  permutation_rank_fixed_ends_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_row_packed (in_row_packed),
    .in_row_length (in_row_length),
    .out_valid     (out_valid),
    .out_rank      (out_rank),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic rank_result_t rank_of_row(cfg_t c, logic [ROW_W-1:0] row,
                                               logic [CNT_W-1:0] len);
    int nw;
    int nh;
    int nt;
    int pos_val [N_POS];
    logic [63:0] acc;
    rank_result_t r;
    nw = c.working;
    nh = c.front;
    nt = c.total;
    for (int k = 0; k < N_POS; k++) begin
      pos_val[k] = (k < len) ? int'(row[POS_BITS*k +: POS_BITS]) : k;
    end
    r.status = ST_OK;
    acc = '0;
    if (nt > N_POS || nh + nw > nt) begin
      r.status = ST_BAD_CFG;
    end else if (len > nt) begin
      r.status = ST_TOO_LONG;
    end else begin
      for (int k = 0; k < nh && r.status == ST_OK; k++) begin
        if (pos_val[k] != k) r.status = ST_FRONT_BAD;
      end
      for (int k = nh + nw; k < nt && r.status == ST_OK; k++) begin
        if (pos_val[k] != k) r.status = ST_BACK_BAD;
      end
    end
    if (r.status == ST_OK) begin
      for (int i = nh; i < nh + nw; i++) begin
        acc = acc * (nh + nw - i);
        for (int j = i + 1; j < nh + nw; j++) begin
          if (pos_val[j] < pos_val[i]) acc = acc + 1;
        end
      end
    end
    r.rank = acc[RANK_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WORKING: cfg_shadow.working = val;
      REG_FRONT:   cfg_shadow.front = val;
      REG_TOTAL:   cfg_shadow.total = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, input int f, input int t);
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, CNT_W'($urandom));
    write_reg(REG_WORKING, CNT_W'(w));
    write_reg(REG_FRONT, CNT_W'(f));
    write_reg(REG_TOTAL, CNT_W'(t));
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_data <= CNT_W'($urandom);
  endtask

  task automatic drain_ranks();
    @(negedge clk);
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 99) < 16) begin
      @(negedge clk);
      start <= 1'b0;
      in_row_packed <= {$urandom, $urandom};
      in_row_length <= CNT_W'($urandom);
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic send_row(input logic [ROW_W-1:0] row, input logic [CNT_W-1:0] len,
                          input bit known, input rank_result_t typed);
    rank_result_t expected;
    @(negedge clk);
    start <= 1'b1;
    in_row_packed <= row;
    in_row_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected = known ? typed : rank_of_row(cfg_shadow, row, len);
    pending_ranks.insert(pending_ranks.size(), expected);
    rows_sent++;
  endtask

  task automatic make_row(output logic [ROW_W-1:0] row, output logic [CNT_W-1:0] len);
    int nw;
    int nh;
    int nt;
    int kind;
    int pick;
    int tmp;
    int vals [N_POS];
    nw = cfg_shadow.working;
    nh = cfg_shadow.front;
    nt = cfg_shadow.total;
    kind = $urandom_range(0, 99);
    row = {$urandom, $urandom};
    len = CNT_W'($urandom_range(0, 31));
    if (nt <= N_POS && nh + nw <= nt && kind < 85) begin
      for (int k = 0; k < N_POS; k++) vals[k] = k;
      if (kind < 75) begin
        for (int i = nh + nw - 1; i > nh; i--) begin
          pick = $urandom_range(nh, i);
          tmp = vals[i];
          vals[i] = vals[pick];
          vals[pick] = tmp;
        end
      end else begin
        for (int k = nh; k < nh + nw; k++) vals[k] = $urandom_range(0, 15);
      end
      if (kind >= 60 && kind < 75) vals[$urandom_range(0, N_POS - 1)] = $urandom_range(0, 15);
      len = CNT_W'(($urandom_range(0, 3) != 0) ? nt : $urandom_range(0, nt));
      for (int k = 0; k < N_POS; k++) begin
        if (k < len) row[POS_BITS*k +: POS_BITS] = POS_BITS'(vals[k]);
      end
    end
  endtask

  task automatic pick_config();
    int nw;
    int nh;
    int nt;
    case ($urandom_range(0, 9))
      0: begin
        nw = $urandom_range(0, 31);
        nh = $urandom_range(0, 31);
        nt = $urandom_range(0, 31);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: begin nw = 16; nh = 0; nt = 16; end
          1: begin nw = 0; nh = 0; nt = 0; end
          2: begin nw = 0; nh = 16; nt = 16; end
          default: begin nw = 1; nh = 15; nt = 16; end
        endcase
      end
      default: begin
        nt = $urandom_range(0, N_POS);
        nw = $urandom_range(0, nt);
        nh = $urandom_range(0, nt - nw);
      end
    endcase
    set_config(nw, nh, nt);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_ranks.size() == 0) begin
        $error("out_rank: result transfer with no row pending, actual %0d", out_rank);
        errors++;
      end else begin
        oldest_rank = pending_ranks.pop_front();
        if (out_rank !== oldest_rank.rank) begin
          $error("out_rank: expected %0d, actual %0d", oldest_rank.rank, out_rank);
          errors++;
        end
        if (out_status !== oldest_rank.status) begin
          $error("out_status: expected %0d, actual %0d", oldest_rank.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[permutation_rank_fixed_ends_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] len;
    rank_result_t typed;
    int batch;
    errors = 0;
    cycles = 0;
    rows_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_row_packed = '0;
    in_row_length = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_shadow.working = 5'd8;
    cfg_shadow.front = 5'd0;
    cfg_shadow.total = 5'd8;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < N_DIR; n++) begin
      if (DIR_ROWS[n].working != cfg_shadow.working || DIR_ROWS[n].front != cfg_shadow.front ||
          DIR_ROWS[n].total != cfg_shadow.total) begin
        drain_ranks();
        set_config(DIR_ROWS[n].working, DIR_ROWS[n].front, DIR_ROWS[n].total);
      end
      typed.rank = DIR_ROWS[n].rank;
      typed.status = DIR_ROWS[n].status;
      maybe_gap(1'b1);
      send_row(DIR_ROWS[n].row, DIR_ROWS[n].len, DIR_ROWS[n].known, typed);
    end

    while (rows_sent < N_DIR + ITEM_TARGET) begin
      drain_ranks();
      pick_config();
      batch = $urandom_range(20, 80);
      for (int n = 0; n < batch; n++) begin
        make_row(row, len);
        maybe_gap(rows_sent < 600 || rows_sent >= 900);
        send_row(row, len, 1'b0, typed);
      end
    end

    drain_ranks();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("[permutation_rank_fixed_ends_top] OK");
    end else begin
      $display("[permutation_rank_fixed_ends_top] ERROR");
    end
    $finish;
  end

endmodule
